>>> src/pem_pkg.sv
// Shared types and constants for the percent encoder.
// Used by the front end, the run queue, the back end and the top level.
package pem_pkg;

    localparam int MAX_RES = 7;
    localparam int CNT_W   = $clog2(MAX_RES + 1);
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FORM_STYLE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PASS_RSV   = CFG_IDX_W'(1);

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    localparam logic [15:0][7:0] HEX_DIGITS = {
        8'h46, 8'h45, 8'h44, 8'h43, 8'h42, 8'h41, 8'h39, 8'h38,
        8'h37, 8'h36, 8'h35, 8'h34, 8'h33, 8'h32, 8'h31, 8'h30
    };

    // one queued run of output words for a single input word
    typedef struct packed {
        logic [MAX_RES-1:0][7:0] bytes;
        logic [CNT_W-1:0]        cnt;
        logic                    eos;
    } t_run;

    typedef struct packed {
        logic push;
        logic full;
    } t_qwr;

endpackage

>>> src/pem_front.sv
// Front end: accepts input words, classifies them and builds output runs.
// Holds the config registers and the pending %HH triplet. Uses pem_pkg.
module pem_front import pem_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_byte,
    input  logic                 i_eos,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic                 i_cfg_data,
    output t_qwr                 o_qwr,
    input  logic                 i_qfull,
    output t_run                 o_run
);

    typedef enum logic [2:0] {
        H_NONE = 3'b001,
        H_PCT  = 3'b010,
        H_HEX  = 3'b100
    } t_hold;

    t_hold      r_hold, n_hold;
    logic [7:0] r_held_hex;
    logic       r_form, r_allow;

    function automatic logic is_hex(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
               (b >= 8'h61 && b <= 8'h66);
    endfunction

    function automatic logic is_alnum(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
               (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function automatic logic is_rsv_char(input logic [7:0] b);
        logic r;
        case (b) inside
            8'h3A, 8'h2F, 8'h3F, 8'h23, 8'h5B, 8'h5D, 8'h40, 8'h21, 8'h24,
            8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h3B, 8'h3D:
                r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    logic       accept;
    logic       f_hold, f_pass;
    logic [1:0] f_n;
    logic [2:0][7:0] f_b;
    logic [CNT_W-1:0] p_n, n_cnt;
    logic [MAX_RES-1:0][7:0] res;

    assign o_ready = !i_qfull;
    assign accept  = i_valid && o_ready;

    // fresh encoding of the incoming byte under the current mode
    always_comb begin
        f_hold = 1'b0;
        f_n    = 2'd0;
        f_b    = {CH_PCT, CH_PCT, CH_PCT};
        f_pass = is_alnum(i_byte) || i_byte == 8'h2D || i_byte == 8'h2E ||
                 i_byte == 8'h5F ||
                 (r_form ? (i_byte == CH_STAR) : (i_byte == CH_TILDE));
        if (!f_pass && r_allow && is_rsv_char(i_byte)) begin
            f_pass = !(r_form && (i_byte == 8'h26 || i_byte == 8'h3D ||
                                  i_byte == CH_PLUS));
        end
        if (r_allow && i_byte == CH_PCT && !i_eos) begin
            f_hold = 1'b1;
        end else if (r_form && i_byte == CH_SPACE) begin
            f_n    = 2'd1;
            f_b[0] = CH_PLUS;
        end else if (f_pass) begin
            f_n    = 2'd1;
            f_b[0] = i_byte;
        end else begin
            f_n    = 2'd3;
            f_b[0] = CH_PCT;
            f_b[1] = HEX_DIGITS[i_byte[7:4]];
            f_b[2] = HEX_DIGITS[i_byte[3:0]];
        end
    end

    always_comb begin
        res    = '0;
        p_n    = '0;
        n_hold = f_hold ? H_PCT : H_NONE;
        unique case (r_hold)
            H_NONE: begin
                p_n = '0;
            end
            H_PCT: begin
                if (is_hex(i_byte) && !i_eos) begin
                    n_hold = H_HEX;
                end else begin
                    res[0] = CH_PCT;
                    res[1] = HEX_DIGITS[CH_PCT[7:4]];
                    res[2] = HEX_DIGITS[CH_PCT[3:0]];
                    p_n    = CNT_W'(3);
                end
            end
            H_HEX: begin
                res[0] = CH_PCT;
                if (is_hex(i_byte)) begin
                    res[1] = r_held_hex;
                    res[2] = i_byte;
                    n_hold = H_NONE;
                end else begin
                    res[1] = HEX_DIGITS[CH_PCT[7:4]];
                    res[2] = HEX_DIGITS[CH_PCT[3:0]];
                    res[3] = r_held_hex;
                    p_n    = CNT_W'(4);
                end
                if (is_hex(i_byte)) begin
                    p_n = CNT_W'(3);
                end
            end
            default: begin
                p_n = '0;
            end
        endcase
        n_cnt = '0;
        if (!(r_hold == H_PCT && is_hex(i_byte) && !i_eos) &&
            !(r_hold == H_HEX && is_hex(i_byte))) begin
            n_cnt = p_n + CNT_W'(f_n);
            case (p_n)
                CNT_W'(3): begin
                    res[3] = f_b[0];
                    res[4] = f_b[1];
                    res[5] = f_b[2];
                end
                CNT_W'(4): begin
                    res[4] = f_b[0];
                    res[5] = f_b[1];
                    res[6] = f_b[2];
                end
                default: begin
                    res[0] = f_b[0];
                    res[1] = f_b[1];
                    res[2] = f_b[2];
                end
            endcase
        end else if (r_hold == H_HEX) begin
            n_cnt = CNT_W'(3);
        end
    end

    assign o_run.bytes = res;
    assign o_run.cnt   = n_cnt;
    assign o_run.eos   = i_eos;
    assign o_qwr.push  = accept && (n_cnt != '0);
    assign o_qwr.full  = i_qfull;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold  <= H_NONE;
            r_form  <= 1'b0;
            r_allow <= 1'b0;
        end else begin
            if (accept) begin
                r_hold <= n_hold;
            end
            if (i_cfg_valid && i_cfg_index == CFG_FORM_STYLE) begin
                r_form <= i_cfg_data;
            end
            if (i_cfg_valid && i_cfg_index == CFG_PASS_RSV) begin
                r_allow <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && r_hold == H_PCT) begin
            r_held_hex <= i_byte;
        end
    end

endmodule

>>> src/pem_queue.sv
// Short queue of output runs between front end and back end.
// Uses pem_pkg for the run type and depth.
module pem_queue import pem_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_qwr i_qwr,
    input  t_run i_run,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_run o_run
);

    t_run              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              push;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign push    = i_qwr.push && !i_qwr.full;
    assign o_run   = r_mem[r_rd];

    function automatic logic [QPTR_W-1:0] nxt(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= nxt(r_wr);
            end
            if (i_pop) begin
                r_rd <= nxt(r_rd);
            end
            if (push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (i_pop && !push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_run;
        end
    end

endmodule

>>> src/pem_back.sv
// Back end: serializes queued runs into one output word per cycle while the receiver is ready.
// Uses pem_pkg for the run type.
module pem_back import pem_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_run       i_run,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_last_of_run,
    output logic       o_string_end
);

    logic [CNT_W-1:0] r_idx;
    logic             last;

    assign o_valid       = !i_empty;
    assign last          = (r_idx == i_run.cnt - CNT_W'(1));
    assign o_byte        = i_run.bytes[r_idx];
    assign o_last_of_run = last;
    assign o_string_end  = last && i_run.eos;
    assign o_pop         = o_valid && i_ready && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (o_valid && i_ready) begin
            r_idx <= last ? '0 : r_idx + CNT_W'(1);
        end
    end

endmodule

>>> src/percent_encoder_multimode.sv
// Top level of the percent encoder: front end, run queue, back end.
// Depends on pem_pkg, pem_front, pem_queue and pem_back.
//
// Input stream: s_axis_tdata carries one raw byte, s_axis_tlast marks the
// final byte of a string. Output stream: m_axis_tdata is one encoded byte,
// m_axis_tuser marks the last word caused by an input word, m_axis_tlast
// the final word of the encoded string.
// Config channel: index 0 form_style, index 1 passes reserved characters;
// always ready, write only while the block is idle.
// An accepted word's run is registered in the run queue and leaves from there.
// Throughput: the output side moves one word per cycle while the receiver is
// ready. A passed byte makes one word, an escaped byte three, and a run after
// a broken triplet up to seven; a two-entry run queue lets input be taken while
// output stalls. A held '%' or hex digit produces no output until resolved.
// Reset clears the mode registers, the held triplet and the queue.
// While the receiver stalls, the current word holds and input is taken
// until the queue fills.
module percent_encoder_multimode import pem_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] in_byte
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // [7:0] out_byte
    output logic                 m_axis_tuser,   // [0] last_of_run
    output logic                 m_axis_tlast,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic                 i_cfg_data
);

    t_qwr qwr;
    t_run run_in, run_out;
    logic qfull, qempty, pop;

    assign o_cfg_ready = 1'b1;

    pem_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_byte      (s_axis_tdata),
        .i_eos       (s_axis_tlast),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_qwr       (qwr),
        .i_qfull     (qfull),
        .o_run       (run_in)
    );

    pem_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qwr   (qwr),
        .i_run   (run_in),
        .o_full  (qfull),
        .i_pop   (pop),
        .o_empty (qempty),
        .o_run   (run_out)
    );

    pem_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (qempty),
        .i_run         (run_out),
        .o_pop         (pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_byte        (m_axis_tdata),
        .o_last_of_run (m_axis_tuser),
        .o_string_end  (m_axis_tlast)
    );

endmodule

>>> src/pem_checker.sv
// Port-level checks for the percent encoder, bound to the top level.
// Depends only on the top-level ports.
module pem_port_checks (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tuser,
    input logic       m_axis_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");

    a_end_on_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
        else $error("string end not on last word of run");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty queue");

endmodule

bind percent_encoder_multimode pem_port_checks u_pem_port_checks (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

>>> sim/pem_checker.sv
// Checker for the percent encoder: watches the input, output and config channels,
// predicts the encoded words for every accepted input word and compares them in order.
// Depends on pem_pkg for the config indexes and character constants.
module pem_checker import pem_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] in_byte
    input  logic                 s_axis_tlast,   // end_of_string
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [7:0]           m_axis_tdata,   // [7:0] out_byte
    input  logic                 m_axis_tuser,   // [0] last_of_run
    input  logic                 m_axis_tlast,   // string_end
    input  logic                 i_cfg_valid,
    input  logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic                 i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        HOLD_NONE  = 3'b001,
        HOLD_PCT   = 3'b010,
        HOLD_DIGIT = 3'b100
    } t_hold_st;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       string_end;
    } t_enc_word;

    t_enc_word  enc_expected[$];
    logic [7:0] run_buf[$];

    logic       mode_form;
    logic       mode_rsv;
    t_hold_st   hold_st;
    logic [7:0] hold_digit;

    function automatic logic [7:0] hex_char(logic [3:0] n);
        return (n < 10) ? 8'("0") + 8'(n) : 8'("A") + 8'(n) - 8'd10;
    endfunction

    function automatic logic is_hex(logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "A" && b <= "F") || (b >= "a" && b <= "f");
    endfunction

    function automatic logic is_alnum(logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    function automatic logic is_rsv_char(logic [7:0] b);
        case (b)
            ":", "/", "?", "#", "[", "]", "@", "!", "$", "&", "'", "(", ")",
            "*", "+", ",", ";", "=": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void emit(logic [7:0] b);
        if (run_buf.size() < MAX_RES)
            run_buf.push_back(b);
    endfunction

    function automatic void emit_escaped(logic [7:0] b);
        emit(CH_PCT);
        emit(hex_char(b[7:4]));
        emit(hex_char(b[3:0]));
    endfunction

    // byte with nothing held before it
    function automatic void encode_plain(logic [7:0] b, logic eos);
        logic pass;
        if (mode_rsv && b == CH_PCT && !eos) begin
            hold_st = HOLD_PCT;
        end else if (mode_form && b == CH_SPACE) begin
            emit(CH_PLUS);
        end else begin
            pass = is_alnum(b) || b == "-" || b == "." || b == "_" ||
                   (mode_form ? (b == CH_STAR) : (b == CH_TILDE));
            if (!pass && mode_rsv && is_rsv_char(b))
                pass = !(mode_form && (b == "&" || b == "=" || b == CH_PLUS));
            if (pass)
                emit(b);
            else
                emit_escaped(b);
        end
    endfunction

    function automatic void encode_word(logic [7:0] b, logic eos);
        t_enc_word w;
        run_buf.delete();
        case (hold_st)
            HOLD_PCT: begin
                if (is_hex(b) && !eos) begin
                    hold_digit = b;
                    hold_st    = HOLD_DIGIT;
                end else begin
                    hold_st = HOLD_NONE;
                    emit_escaped(CH_PCT);
                    encode_plain(b, eos);
                end
            end
            HOLD_DIGIT: begin
                hold_st = HOLD_NONE;
                if (is_hex(b)) begin
                    emit(CH_PCT);
                    emit(hold_digit);
                    emit(b);
                end else begin
                    emit_escaped(CH_PCT);
                    emit(hold_digit);
                    encode_plain(b, eos);
                end
            end
            default: encode_plain(b, eos);
        endcase
        foreach (run_buf[i]) begin
            w.out_byte    = run_buf[i];
            w.last_of_run = (i == run_buf.size() - 1);
            w.string_end  = w.last_of_run && eos;
            enc_expected.push_back(w);
        end
    endfunction

    always @(posedge i_clk) begin
        t_enc_word want;
        if (!i_rst_n) begin
            enc_expected.delete();
            mode_form    = 1'b0;
            mode_rsv     = 1'b0;
            hold_st      = HOLD_NONE;
            hold_digit   = 8'h00;
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (enc_expected.size() == 0) begin
                    $error("unexpected output word: out_byte %h last_of_run %b string_end %b",
                           m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    o_fail_count++;
                end else begin
                    want = enc_expected.pop_front();
                    o_checked++;
                    if (m_axis_tdata !== want.out_byte) begin
                        $error("out_byte: expected %h, got %h", want.out_byte, m_axis_tdata);
                        o_fail_count++;
                    end
                    if (m_axis_tuser !== want.last_of_run) begin
                        $error("last_of_run: expected %b, got %b", want.last_of_run,
                               m_axis_tuser);
                        o_fail_count++;
                    end
                    if (m_axis_tlast !== want.string_end) begin
                        $error("string_end: expected %b, got %b", want.string_end,
                               m_axis_tlast);
                        o_fail_count++;
                    end
                end
            end
            // a word taken at this edge still sees the old mode
            if (s_axis_tvalid && s_axis_tready)
                encode_word(s_axis_tdata, s_axis_tlast);
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_FORM_STYLE)
                    mode_form = i_cfg_data;
                else if (i_cfg_index == CFG_PASS_RSV)
                    mode_rsv = i_cfg_data;
            end
        end
        o_pending = enc_expected.size();
    end

endmodule

>>> sim/testbench.sv
// Top of the percent encoder testbench: clock, reset, stimulus and verdict.
// Depends on pem_pkg, percent_encoder_multimode and pem_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pem_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_3 = CFG_IDX_W'(3);
    localparam int STALL_LONG = 400;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_WORDS = 54;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = 8'h00;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic                 i_cfg_data = 1'b0;

    int fail_count;
    int pending;
    int checked;

    int   words_sent;
    int   cfg_writes;
    int   str_left;
    bit   quiet;
    bit   hold_req;
    logic [7:0] pat_q[$];

    always #5 i_clk = ~i_clk;

    percent_encoder_multimode dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    pem_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    // called at a falling edge; returns at the falling edge after the word is taken
    task automatic send_word(logic [7:0] b, logic last);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(string s, bit last_at_end);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], last_at_end && (i == s.len() - 1));
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_hex();
        string hexset;
        hexset = "0123456789ABCDEFabcdef";
        return hexset[$urandom_range(0, hexset.len() - 1)];
    endfunction

    // mostly triplets and interesting characters, the rest any byte
    task automatic next_byte(output logic [7:0] b, output logic last);
        string spec;
        int    r;
        spec = "%% ~*-._:/?#[]@!$&'()+,;=";
        if (pat_q.size() == 0) begin
            r = $urandom_range(0, 99);
            if (r < 20) begin
                pat_q.push_back(CH_PCT);
                pat_q.push_back(pick_hex());
                pat_q.push_back(pick_hex());
            end else if (r < 28) begin
                pat_q.push_back(CH_PCT);
                pat_q.push_back(pick_hex());
                pat_q.push_back(8'($urandom_range(0, 255)));
            end else if (r < 34) begin
                pat_q.push_back(CH_PCT);
                pat_q.push_back(8'($urandom_range(0, 255)));
            end else if (r < 62) begin
                pat_q.push_back(spec[$urandom_range(0, spec.len() - 1)]);
            end else begin
                pat_q.push_back(8'($urandom_range(0, 255)));
            end
        end
        b = pat_q.pop_front();
        str_left--;
        last = (str_left <= 0);
        if (last)
            str_left = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(1, 12);
    endtask

    // output side: random stalls, one long hold-off on request
    initial begin
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (STALL_LONG) @(negedge i_clk);
            end else if (!quiet && $urandom_range(0, 2) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
            end
        end
    end

    initial begin
        logic [7:0] b;
        logic       last;
        logic [1:0] mode;
        words_sent = 0;
        cfg_writes = 0;
        str_left   = 5;
        quiet      = 1'b0;
        hold_req   = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // plain mode: byte extremes, tilde, star, space
        write_reg(CFG_FORM_STYLE, 1'b0);
        write_reg(CFG_PASS_RSV, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_text("~* ", 1'b1);

        // form + reserved: triplet, broken percent, broken digit, percent at end
        wait_idle();
        write_reg(CFG_FORM_STYLE, 1'b1);
        write_reg(CFG_PASS_RSV, 1'b1);
        send_text("%41%G%a&+", 1'b0);
        send_word(CH_PCT, 1'b1);

        // mode change with two bytes held, triplet closed on the final byte
        send_text("%4", 1'b0);
        wait_idle();
        write_reg(CFG_FORM_STYLE, 1'b0);
        write_reg(CFG_PASS_RSV, 1'b0);
        send_word("f", 1'b1);

        // reserved only: percent breaking a held percent
        wait_idle();
        write_reg(CFG_PASS_RSV, 1'b1);
        write_reg(CFG_UNUSED_2, 1'b1);
        write_reg(CFG_UNUSED_3, 1'b1);
        send_text("%%4B", 1'b1);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            mode = (ph < 4) ? 2'(ph) : 2'($urandom_range(0, 3));
            wait_idle();
            write_reg(CFG_FORM_STYLE, mode[0]);
            write_reg(CFG_PASS_RSV, mode[1]);
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? CFG_UNUSED_2 : CFG_UNUSED_3,
                          1'($urandom_range(0, 1)));
            if (ph == 2)
                hold_req = 1'b1;
            if (ph == RAND_PHASES - 1)
                quiet = 1'b1;
            repeat (PHASE_WORDS) begin
                next_byte(b, last);
                send_word(b, last);
            end
        end

        wait_idle();
        repeat (20) @(negedge i_clk);
        $display("Sent %0d input words through all four modes with %0d register writes,",
                 words_sent, cfg_writes);
        $display("checked %0d output words, including one long output stall.", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("percent_encoder_multimode test passed");
        end else begin
            $display("percent_encoder_multimode test failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("percent_encoder_multimode test failed");
        $finish;
    end

endmodule
